@@ design/assert_macros.svh @@
// assertion macros shared by the tokenizer modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define DST_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define DST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define DST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ design/dstok_pkg.sv @@
// types, constants and the per-phase step function of the dependency tokenizer
// no dependencies; imported by every tokenizer module
`timescale 1ns / 1ps

package dstok_pkg;

  localparam int NAME_MAX    = 64;
  localparam int VERSION_MAX = 32;
  localparam int NAME_CNT_W  = $clog2(NAME_MAX);
  localparam int VER_CNT_W   = $clog2(VERSION_MAX);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_VERSION = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // constraint operators
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_EQ   = 3'd1;
  localparam logic [2:0] OP_GE   = 3'd2;
  localparam logic [2:0] OP_GT   = 3'd3;
  localparam logic [2:0] OP_LE   = 3'd4;
  localparam logic [2:0] OP_LT   = 3'd5;

  // parse phases
  localparam logic [3:0] PH_LEAD       = 4'd0;
  localparam logic [3:0] PH_NAME       = 4'd1;
  localparam logic [3:0] PH_POSTNAME   = 4'd2;
  localparam logic [3:0] PH_EXTRAS     = 4'd3;
  localparam logic [3:0] PH_POSTEXTRAS = 4'd4;
  localparam logic [3:0] PH_OP         = 4'd5;
  localparam logic [3:0] PH_GT         = 4'd6;
  localparam logic [3:0] PH_LT         = 4'd7;
  localparam logic [3:0] PH_EQ         = 4'd8;
  localparam logic [3:0] PH_TILDE      = 4'd9;
  localparam logic [3:0] PH_EXTRAEQ    = 4'd10;
  localparam logic [3:0] PH_PREVER     = 4'd11;
  localparam logic [3:0] PH_VER        = 4'd12;
  localparam logic [3:0] PH_DONE       = 4'd13;

  // characters
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] op;
    logic [5:0] name_len;
    logic [4:0] ver_len;
    logic       last;
  } res_t;

  // results handed from the parser to the queue in one request
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       cont;
    logic       emit;
    logic       is_ver;
    logic [7:0] ch;
    logic       op_wr;
    logic [2:0] op;
  } step_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

  function automatic logic name_stop(input logic [7:0] c);
    return (c == CH_GT) || (c == CH_LT) || (c == CH_EQ) || (c == CH_BANG) ||
           (c == CH_TILDE) || (c == CH_SEMI) || (c == CH_LBRK) || is_quote(c) ||
           (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic version_stop(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_SPACE) || (c == CH_TAB) ||
           is_quote(c) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) ||
           (c == CH_BANG);
  endfunction

  // one phase of the parse; cont means the same byte goes on to the new phase
  function automatic step_t phase_step(input logic [3:0] ph, input logic [7:0] c,
                                       input logic name_full, input logic ver_full);
    step_t s;
    s = '{phase: ph, cont: 1'b0, emit: 1'b0, is_ver: 1'b0, ch: 8'd0,
          op_wr: 1'b0, op: OP_NONE};
    unique case (ph) inside
      PH_LEAD: begin
        if (!(is_space(c) || is_quote(c))) begin
          s.phase = PH_NAME;
          s.cont  = 1'b1;
        end
      end
      PH_NAME: begin
        if (name_stop(c) || name_full) begin
          s.phase = PH_POSTNAME;
          s.cont  = 1'b1;
        end else begin
          s.emit = 1'b1;
          if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) s.ch = c | 8'h20;
          else if (c == CH_UNDER) s.ch = CH_HYPHEN;
          else s.ch = c;
        end
      end
      PH_POSTNAME: begin
        if (is_space(c)) begin
          s.phase = PH_POSTNAME;
        end else if (c == CH_LBRK) begin
          s.phase = PH_EXTRAS;
        end else begin
          s.phase = PH_OP;
          s.cont  = 1'b1;
        end
      end
      PH_EXTRAS: begin
        if (c == CH_RBRK) s.phase = PH_POSTEXTRAS;
      end
      PH_POSTEXTRAS: begin
        if (!is_space(c)) begin
          s.phase = PH_OP;
          s.cont  = 1'b1;
        end
      end
      PH_OP: begin
        if (c == CH_GT) s.phase = PH_GT;
        else if (c == CH_LT) s.phase = PH_LT;
        else if (c == CH_EQ) s.phase = PH_EQ;
        else if (c == CH_TILDE) s.phase = PH_TILDE;
        else s.phase = PH_DONE;
      end
      PH_GT, PH_LT, PH_EQ: begin
        s.op_wr = 1'b1;
        if (c == CH_EQ) begin
          s.op    = (ph == PH_GT) ? OP_GE : (ph == PH_LT) ? OP_LE : OP_EQ;
          s.phase = PH_EXTRAEQ;
        end else begin
          s.op    = (ph == PH_GT) ? OP_GT : (ph == PH_LT) ? OP_LT : OP_EQ;
          s.phase = PH_PREVER;
          s.cont  = 1'b1;
        end
      end
      PH_TILDE: begin
        if (c == CH_EQ) begin
          s.op_wr = 1'b1;
          s.op    = OP_GE;
          s.phase = PH_EXTRAEQ;
        end else begin
          s.phase = PH_DONE;
        end
      end
      PH_EXTRAEQ: begin
        s.phase = PH_PREVER;
        s.cont  = (c != CH_EQ);
      end
      PH_PREVER: begin
        if (!is_space(c)) begin
          s.phase = PH_VER;
          s.cont  = 1'b1;
        end
      end
      PH_VER: begin
        if (version_stop(c) || ver_full) begin
          s.phase = PH_DONE;
        end else begin
          s.emit   = 1'b1;
          s.is_ver = 1'b1;
          s.ch     = c;
        end
      end
      default: begin
        s.phase = PH_DONE;
      end
    endcase
    return s;
  endfunction

endpackage

@@ design/dstok_parse.sv @@
// input register, parse state and per-byte result generation of the tokenizer
// depends on dstok_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dstok_parse
  import dstok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_room,
  output push_t      push
);

  logic                  hold_vld_r, hold_vld_nxt;
  logic [7:0]            hold_ch_r;
  logic                  hold_last_r;
  logic [3:0]            phase_r, phase_nxt;
  logic [NAME_CNT_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [VER_CNT_W-1:0]  ver_cnt_r, ver_cnt_nxt;
  logic [2:0]            op_r, op_nxt;

  logic                  adv;
  logic                  emit, is_ver, run;
  logic [7:0]            ch;
  logic [3:0]            ph;
  logic [2:0]            op;
  step_t                 s;
  logic [NAME_CNT_W-1:0] name_cnt_a;
  logic [VER_CNT_W-1:0]  ver_cnt_a;
  logic [8:0]            name_wide, ver_wide;
  logic [5:0]            name_len;
  logic [4:0]            ver_len;
  res_t                  char_res, sum_res;

  assign adv       = hold_vld_r && q_room;
  assign in_tready = !hold_vld_r || q_room;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (in_tready) hold_vld_nxt = in_tvalid;
  end

  // walk the phases for the held byte; four steps cover the longest chain
  always_comb begin
    ph     = phase_r;
    op     = op_r;
    emit   = 1'b0;
    is_ver = 1'b0;
    ch     = 8'd0;
    run    = 1'b1;
    s      = '0;
    for (int i = 0; i < 4; i++) begin
      if (run) begin
        s = phase_step(ph, hold_ch_r,
                       name_cnt_r >= NAME_CNT_W'(NAME_MAX - 1),
                       ver_cnt_r >= VER_CNT_W'(VERSION_MAX - 1));
        ph = s.phase;
        if (s.op_wr) op = s.op;
        if (s.emit) begin
          emit   = 1'b1;
          is_ver = s.is_ver;
          ch     = s.ch;
        end
        run = s.cont;
      end
    end
    // a nul byte ends parsing outright
    if (hold_ch_r == CH_NUL) begin
      ph   = PH_DONE;
      op   = op_r;
      emit = 1'b0;
    end
  end

  always_comb begin
    name_cnt_a = name_cnt_r + NAME_CNT_W'(emit && !is_ver);
    ver_cnt_a  = ver_cnt_r + VER_CNT_W'(emit && is_ver);
    name_wide  = 9'(name_cnt_a);
    ver_wide   = 9'(ver_cnt_a);
    name_len   = (name_wide > 9'd63) ? 6'd63 : name_wide[5:0];
    ver_len    = (ver_wide > 9'd31) ? 5'd31 : ver_wide[4:0];

    char_res.kind     = is_ver ? KIND_VERSION : KIND_NAME;
    char_res.value    = ch;
    char_res.op       = OP_NONE;
    char_res.name_len = name_len;
    char_res.ver_len  = ver_len;
    char_res.last     = 1'b0;

    sum_res.kind     = KIND_SUMMARY;
    sum_res.value    = 8'd0;
    sum_res.op       = (ver_cnt_a != '0) ? op : OP_NONE;
    sum_res.name_len = name_len;
    sum_res.ver_len  = ver_len;
    sum_res.last     = 1'b1;

    push.r0 = emit ? char_res : sum_res;
    push.r1 = sum_res;
    push.n  = 2'd0;
    if (adv) push.n = 2'(emit) + 2'(hold_last_r);

    phase_nxt    = phase_r;
    name_cnt_nxt = name_cnt_r;
    ver_cnt_nxt  = ver_cnt_r;
    op_nxt       = op_r;
    if (adv) begin
      if (hold_last_r) begin
        phase_nxt    = PH_LEAD;
        name_cnt_nxt = '0;
        ver_cnt_nxt  = '0;
        op_nxt       = OP_NONE;
      end else begin
        phase_nxt    = ph;
        name_cnt_nxt = name_cnt_a;
        ver_cnt_nxt  = ver_cnt_a;
        op_nxt       = op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      phase_r    <= PH_LEAD;
      name_cnt_r <= '0;
      ver_cnt_r  <= '0;
      op_r       <= OP_NONE;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      phase_r    <= phase_nxt;
      name_cnt_r <= name_cnt_nxt;
      ver_cnt_r  <= ver_cnt_nxt;
      op_r       <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      hold_ch_r   <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

  `DST_ASSERT_NEXT(a_reset_after_last, clk, rst_n, adv && hold_last_r,
    phase_r == PH_LEAD && name_cnt_r == '0 && ver_cnt_r == '0 && op_r == OP_NONE)
  `DST_ASSERT_IMPL(a_push_only_on_adv, clk, rst_n, push.n != 2'd0, adv)
  `DST_ASSERT_IMPL(a_push_count, clk, rst_n, push.n == 2'd2, emit && hold_last_r)

endmodule

@@ design/dstok_outq.sv @@
// four-entry result queue between the parser and the output channel
// depends on dstok_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dstok_outq
  import dstok_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  q_room,
  output logic  out_tvalid,
  input  logic  out_tready,
  output res_t  head
);

  res_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign head       = ent_r[head_r];
  // room for two results, ignoring a pop in the same cycle
  assign q_room     = (cnt_r <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));

  always_comb begin
    head_nxt = head_r + QPTR_W'(pop);
    tail_nxt = tail_r + QPTR_W'(push.n);
    cnt_nxt  = cnt_r + (QPTR_W + 1)'(push.n) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) ent_r[tail_r] <= push.r0;
    if (push.n == 2'd2) ent_r[tail_r + QPTR_W'(1)] <= push.r1;
  end

  `DST_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= (QPTR_W + 1)'(QUEUE_DEPTH))
  `DST_ASSERT_IMPL(a_no_overfill, clk, rst_n, push.n != 2'd0, q_room)
  `DST_ASSERT_ALWAYS(a_ptr_gap, clk, rst_n, QPTR_W'(cnt_r) == QPTR_W'(tail_r - head_r))

endmodule

@@ design/dependency_spec_tokenizer_unit.sv @@
// top level of the dependency string tokenizer: parser stage and result queue
// depends on dstok_pkg, dstok_parse and dstok_outq
`timescale 1ns / 1ps

// One byte of a dependency string enters per request on the in_ channel, in_tlast on
// the final byte. The block skips leading blanks and quotes, emits the package name
// (lower case, underscore as hyphen), skips an extras group in brackets, decodes the
// version operator and emits the version bytes; the final byte adds an end summary
// with the operator and both lengths, and the parse state returns to its start.
// A byte is taken every cycle unless in_tready is low: it is held in an input register, parsed there
// in a single pass and its zero, one or two results are written to a four-entry result
// queue, which feeds out_ directly; a result thus passes the input register and a queue entry.
// in_tready falls while a byte waits in the input register and the queue holds more than two results.

module dependency_spec_tokenizer_unit
  import dstok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // char_value, constraint_op, name_length, version_length, zero fill
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_result
);

  push_t push;
  logic  q_room;
  res_t  head;

  dstok_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_room    (q_room),
    .push      (push)
  );

  dstok_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .q_room     (q_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {2'b00, head.ver_len, head.name_len, head.op, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ dv/dependency_spec_tokenizer_unit_test.sv @@
// self-checking testbench for dependency_spec_tokenizer_unit: random and directed strings,
// a byte-level predictor of the emitted tokens and a scoreboard on the out_ stream
// depends on dstok_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module dependency_spec_tokenizer_unit_test;
  import dstok_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 16;

  typedef struct {
    logic [7:0] code;
    logic       fin;
  } char_req_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] op;
    logic [5:0] name_len;
    logic [4:0] ver_len;
    logic       last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // char_code
  logic        in_tlast = 1'b0;   // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // char_value, constraint_op, name_length, version_length, zero fill
  logic [1:0]  out_tuser;         // kind
  logic        out_tlast;         // last_result

  char_req_t pending_chars[$];
  token_t    expected_tokens[$];

  // predictor state
  logic [3:0] tok_phase = PH_LEAD;
  int         name_seen = 0;
  int         ver_seen = 0;
  logic [2:0] held_op = OP_NONE;

  int  send_idle_pct = 16;
  int  recv_idle_pct = 86;
  bit  hold_req = 1'b0;
  bit  hold_ack = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  error_count = 0;
  int  bytes_sent = 0;
  int  strings_sent = 0;
  int  tokens_checked = 0;
  int  summaries_with_op = 0;
  char_req_t next_char;
  token_t    want;

  dependency_spec_tokenizer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_quote_char(input logic [7:0] c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

  function automatic bit ends_name(input logic [7:0] c);
    case (c) inside
      CH_GT, CH_LT, CH_EQ, CH_BANG, CH_TILDE, CH_SEMI, CH_LBRK, CH_SQUOTE, CH_DQUOTE,
      CH_COMMA, CH_SPACE, CH_TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit ends_version(input logic [7:0] c);
    case (c) inside
      CH_COMMA, CH_SEMI, CH_SPACE, CH_TAB, CH_SQUOTE, CH_DQUOTE, CH_LT, CH_GT, CH_EQ,
      CH_BANG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_token(input logic [1:0] kind, input logic [7:0] value,
                                     input logic [2:0] op, input logic last);
    token_t t;
    t.kind     = kind;
    t.value    = value;
    t.op       = op;
    t.name_len = (name_seen > 63) ? 6'd63 : name_seen[5:0];
    t.ver_len  = (ver_seen > 31) ? 5'd31 : ver_seen[4:0];
    t.last     = last;
    expected_tokens.push_back(t);
  endfunction

  // advance the parse by one byte; a byte may fall through several phases
  function automatic void tokenize_char(input logic [7:0] code, input logic fin);
    logic [7:0] c;
    bit again;
    c = code;
    if (c == CH_NUL) begin
      tok_phase = PH_DONE;
    end else begin
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (tok_phase) inside
          PH_LEAD: begin
            if (!is_blank(c) && !is_quote_char(c)) begin
              tok_phase = PH_NAME;
              again = 1'b1;
            end
          end
          PH_NAME: begin
            if (ends_name(c) || name_seen >= NAME_MAX - 1) begin
              tok_phase = PH_POSTNAME;
              again = 1'b1;
            end else begin
              if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + 8'd32;
              else if (c == CH_UNDER) c = CH_HYPHEN;
              name_seen++;
              push_token(KIND_NAME, c, OP_NONE, 1'b0);
            end
          end
          PH_POSTNAME: begin
            if (c == CH_LBRK) begin
              tok_phase = PH_EXTRAS;
            end else if (!is_blank(c)) begin
              tok_phase = PH_OP;
              again = 1'b1;
            end
          end
          PH_EXTRAS: begin
            if (c == CH_RBRK) tok_phase = PH_POSTEXTRAS;
          end
          PH_POSTEXTRAS: begin
            if (!is_blank(c)) begin
              tok_phase = PH_OP;
              again = 1'b1;
            end
          end
          PH_OP: begin
            case (c)
              CH_GT:    tok_phase = PH_GT;
              CH_LT:    tok_phase = PH_LT;
              CH_EQ:    tok_phase = PH_EQ;
              CH_TILDE: tok_phase = PH_TILDE;
              default:  tok_phase = PH_DONE;
            endcase
          end
          PH_GT, PH_LT, PH_EQ: begin
            if (c == CH_EQ) begin
              held_op = (tok_phase == PH_GT) ? OP_GE : (tok_phase == PH_LT) ? OP_LE : OP_EQ;
              tok_phase = PH_EXTRAEQ;
            end else begin
              held_op = (tok_phase == PH_GT) ? OP_GT : (tok_phase == PH_LT) ? OP_LT : OP_EQ;
              tok_phase = PH_PREVER;
              again = 1'b1;
            end
          end
          PH_TILDE: begin
            if (c == CH_EQ) begin
              held_op = OP_GE;
              tok_phase = PH_EXTRAEQ;
            end else begin
              tok_phase = PH_DONE;
            end
          end
          PH_EXTRAEQ: begin
            // a further '=' after the operator is swallowed, anything else goes on to the version
            tok_phase = PH_PREVER;
            again = (c != CH_EQ);
          end
          PH_PREVER: begin
            if (!is_blank(c)) begin
              tok_phase = PH_VER;
              again = 1'b1;
            end
          end
          PH_VER: begin
            if (ends_version(c) || ver_seen >= VERSION_MAX - 1) begin
              tok_phase = PH_DONE;
            end else begin
              ver_seen++;
              push_token(KIND_VERSION, c, OP_NONE, 1'b0);
            end
          end
          default: tok_phase = PH_DONE;
        endcase
      end
    end
    if (fin) begin
      push_token(KIND_SUMMARY, 8'd0, (ver_seen > 0) ? held_op : OP_NONE, 1'b1);
      tok_phase = PH_LEAD;
      name_seen = 0;
      ver_seen  = 0;
      held_op   = OP_NONE;
    end
  endfunction

  function automatic void queue_char(input logic [7:0] c, input logic fin);
    char_req_t r;
    r.code = c;
    r.fin  = fin;
    pending_chars.push_back(r);
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5)) inside
      0, 1:    return CH_SPACE;
      2:       return CH_TAB;
      3:       return 8'h0A;
      4:       return CH_CR;
      default: return 8'(8'h0B + $urandom_range(1));
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(9)) inside
      0, 1, 2: return 8'(8'h61 + $urandom_range(25));
      3, 4:    return 8'(CH_UPPER_A + $urandom_range(25));
      5, 6:    return 8'(8'h30 + $urandom_range(9));
      7:       return CH_UNDER;
      8:       return $urandom_range(1) ? CH_HYPHEN : 8'h2E;
      default: return 8'(8'h80 + $urandom_range(127));
    endcase
  endfunction

  function automatic logic [7:0] pick_ver_char();
    case ($urandom_range(9)) inside
      0, 1, 2, 3, 4, 5: return 8'(8'h30 + $urandom_range(9));
      6:       return 8'h2E;
      7:       return $urandom_range(1) ? 8'h2A : 8'h2B;
      8:       return 8'(8'h61 + $urandom_range(25));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // one requirement string: mostly well formed, some truncated, some junk
  function automatic void add_spec();
    logic [7:0] s[$];
    int roll, n, keep;
    roll = $urandom_range(99);
    if (roll < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(255)));
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) s.push_back($urandom_range(1) ? pick_blank() : CH_DQUOTE);
      n = ($urandom_range(24) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 8);
      repeat (n) s.push_back(pick_name_char());
      if ($urandom_range(3) == 0) s.push_back(pick_blank());
      if ($urandom_range(3) == 0) begin
        s.push_back(CH_LBRK);
        n = $urandom_range(0, 5);
        repeat (n) s.push_back($urandom_range(4) == 0 ? CH_COMMA : pick_name_char());
        if ($urandom_range(7) != 0) s.push_back(CH_RBRK);
        if ($urandom_range(5) == 0) s.push_back(CH_LBRK);
        if ($urandom_range(1)) s.push_back(pick_blank());
      end
      case ($urandom_range(11))
        0: begin s.push_back(CH_GT); s.push_back(CH_EQ); end
        1: begin s.push_back(CH_LT); s.push_back(CH_EQ); end
        2: begin s.push_back(CH_EQ); s.push_back(CH_EQ); end
        3: begin s.push_back(CH_EQ); s.push_back(CH_EQ); s.push_back(CH_EQ); end
        4: begin s.push_back(CH_TILDE); s.push_back(CH_EQ); end
        5: s.push_back(CH_GT);
        6: s.push_back(CH_LT);
        7: s.push_back(CH_EQ);
        8: begin s.push_back(CH_BANG); s.push_back(CH_EQ); end
        9: begin s.push_back(CH_TILDE); s.push_back(pick_name_char()); end
        10: begin s.push_back(CH_GT); s.push_back(CH_EQ); s.push_back(CH_EQ); end
        default: ;
      endcase
      if ($urandom_range(3) == 0) s.push_back(pick_blank());
      n = ($urandom_range(24) == 0) ? $urandom_range(26, 36) : $urandom_range(0, 6);
      repeat (n) s.push_back(pick_ver_char());
      case ($urandom_range(5))
        0: begin s.push_back(CH_SEMI); s.push_back(pick_name_char()); end
        1: begin s.push_back(CH_COMMA); s.push_back(CH_LT); s.push_back(8'h33); end
        2: s.push_back(pick_blank());
        3: s.push_back(CH_SQUOTE);
        default: ;
      endcase
      if (roll < 16) s[$urandom_range(s.size() - 1)] = CH_NUL;
    end
    keep = (roll >= 10 && roll < 20) ? $urandom_range(1, s.size()) : s.size();
    for (int i = 0; i < keep; i++) queue_char(s[i], i == keep - 1);
  endfunction

  function automatic void fill_random(input int count);
    int goal;
    goal = pending_chars.size() + count;
    while (pending_chars.size() < goal) add_spec();
  endfunction

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_tvalid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  function automatic void check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      error_count++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tokenize_char(in_tdata, in_tlast);
        bytes_sent++;
        if (in_tlast) strings_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_char.code;
          in_tlast  <= next_char.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h tlast %0b",
                   $time, out_tuser, out_tdata, out_tlast);
          error_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("char_value", want.value, out_tdata[7:0]);
          check_field("constraint_op", want.op, out_tdata[10:8]);
          check_field("name_length", want.name_len, out_tdata[16:11]);
          check_field("version_length", want.ver_len, out_tdata[21:17]);
          check_field("tdata fill", 0, out_tdata[23:22]);
          check_field("last_result", want.last, out_tlast);
          tokens_checked++;
          if (want.last && want.op != OP_NONE) summaries_with_op++;
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack   <= hold_req;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings: quote, case folding, extras, tilde form, '!=', triple '=',
    // stop after version, extreme bytes, zero byte, empty name
    queue_text("'Ab_[x]~=1");
    queue_text("x!=2");
    queue_text("y===3;");
    queue_char(8'hFF, 1'b1);
    queue_char(CH_NUL, 1'b1);
    queue_text("\t<2");
    wait_drained();

    fill_random(600);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 16;
    fill_random(600);
    wait_drained();

    // no idling, with one long output hold at the start so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = ~hold_req;
    fill_random(525);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d bytes in %0d strings, %0d results checked", bytes_sent,
             strings_sent, tokens_checked);
    $display("%0d summaries carried an operator, %0d errors", summaries_with_op, error_count);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
